// File: sv/grid_line_cell_traversal_assert.svh
// assertion macros for the grid line cell traversal checker
`ifndef GRID_LINE_CELL_TRAVERSAL_ASSERT_SVH
`define GRID_LINE_CELL_TRAVERSAL_ASSERT_SVH

// same-cycle implication
`define GLCT_AP_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glct check failed: same-cycle implication");

// next-cycle implication
`define GLCT_AP_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glct check failed: next-cycle implication");

`endif

// File: sv/glct_pkg.sv
// shared types, codes and microcode table of the grid line cell traversal
`timescale 1ns / 1ps
`default_nettype none

package glct_pkg;

    localparam int CELL_W       = 5;
    localparam int MAX_SPAN_DEF = 32;
    localparam int PC_W         = 3;

    typedef logic [CELL_W-1:0] coord_t;
    typedef logic [PC_W-1:0]   pc_t;

    // output select
    localparam logic [1:0] SEL_CELL  = 2'd0;
    localparam logic [1:0] SEL_PEND  = 2'd1;
    localparam logic [1:0] SEL_FINAL = 2'd2;
    localparam logic [1:0] SEL_ZERO  = 2'd3;

    // datapath ops
    localparam logic [1:0] OP_NOP  = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_INIT = 2'd2;
    localparam logic [1:0] OP_STEP = 2'd3;

    // jump kinds
    localparam logic [2:0] JMP_NEXT   = 3'd0;
    localparam logic [2:0] JMP_GOTO   = 3'd1;
    localparam logic [2:0] JMP_WAIT   = 3'd2;
    localparam logic [2:0] JMP_IFZERO = 3'd3;
    localparam logic [2:0] JMP_COLUMN = 3'd4;

    // program addresses
    localparam pc_t A_IDLE  = 3'd0;
    localparam pc_t A_DISP  = 3'd1;
    localparam pc_t A_CELL  = 3'd2;
    localparam pc_t A_PEND  = 3'd3;
    localparam pc_t A_ZERO  = 3'd4;
    localparam pc_t A_FINAL = 3'd5;

    typedef struct packed {
        logic       ready;
        logic       emit;
        logic [1:0] sel;
        logic       last;
        logic [1:0] op;
        logic [2:0] jmp;
        pc_t        target;
    } uword_t;

    typedef struct packed {
        logic span_zero;
        logic col_end;
        logic wrap;
    } stat_t;

    function automatic uword_t mk_word(input logic ready, input logic emit,
                                       input logic [1:0] sel, input logic last,
                                       input logic [1:0] op, input logic [2:0] jmp,
                                       input pc_t target);
        uword_t w;
        w.ready  = ready;
        w.emit   = emit;
        w.sel    = sel;
        w.last   = last;
        w.op     = op;
        w.jmp    = jmp;
        w.target = target;
        return w;
    endfunction

    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        unique case (pc)
            A_IDLE:  w = mk_word(1'b1, 1'b0, SEL_ZERO,  1'b0, OP_LOAD, JMP_WAIT,   A_IDLE);
            A_DISP:  w = mk_word(1'b0, 1'b0, SEL_ZERO,  1'b0, OP_INIT, JMP_IFZERO, A_ZERO);
            A_CELL:  w = mk_word(1'b0, 1'b1, SEL_CELL,  1'b0, OP_STEP, JMP_COLUMN, A_FINAL);
            A_PEND:  w = mk_word(1'b0, 1'b1, SEL_PEND,  1'b0, OP_NOP,  JMP_GOTO,   A_CELL);
            A_ZERO:  w = mk_word(1'b0, 1'b1, SEL_ZERO,  1'b1, OP_NOP,  JMP_GOTO,   A_IDLE);
            A_FINAL: w = mk_word(1'b0, 1'b1, SEL_FINAL, 1'b1, OP_NOP,  JMP_GOTO,   A_IDLE);
            default: w = mk_word(1'b0, 1'b0, SEL_ZERO,  1'b0, OP_NOP,  JMP_GOTO,   A_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: sv/grid_line_cell_traversal.sv
// top level of the grid line cell traversal
`timescale 1ns / 1ps
`default_nettype none

// Walks the grid cells crossed by the line from (0,0) to (span_x, span_y),
// span_y clamped to span_x. An item is taken when start is high and busy is
// low. In the cycle after the accept the sequencer sets up the column, row and
// remainder registers, and from then on every step of the microcode emits one
// cell, and busy stays high while the line of n cells is made (n is at most 62;
// a span_x of zero gives the single cell (0,0)). Each cell appears on cell_x /
// cell_y for exactly one cycle with valid high, in the cycle after the step that
// made it, and last_cell marks the final one. There is no back
// pressure: the receiver must take every cell in the cycle it is shown.
module grid_line_cell_traversal #(
    parameter int MAX_SPAN = glct_pkg::MAX_SPAN_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire glct_pkg::coord_t span_x,
    input  wire glct_pkg::coord_t span_y,
    output logic                  valid,
    output glct_pkg::coord_t      cell_x,
    output glct_pkg::coord_t      cell_y,
    output logic                  last_cell
);

    glct_pkg::uword_t ctrl;
    glct_pkg::stat_t  stat;

    glct_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    glct_dpath #(
        .MAX_SPAN (MAX_SPAN)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .span_x    (span_x),
        .span_y    (span_y),
        .stat      (stat),
        .valid     (valid),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .last_cell (last_cell)
    );

    assign busy = !ctrl.ready;

endmodule

`default_nettype wire

// File: sv/glct_useq.sv
// microcode sequencer: step counter, control store and jump logic
`timescale 1ns / 1ps
`default_nettype none

module glct_useq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire glct_pkg::stat_t stat,
    output glct_pkg::uword_t     ctrl
);

    glct_pkg::pc_t    pc_reg;
    glct_pkg::pc_t    pc_next;
    glct_pkg::pc_t    pc_inc;
    glct_pkg::uword_t uw;

    assign uw     = glct_pkg::ucode(pc_reg);
    assign pc_inc = pc_reg + glct_pkg::pc_t'(1);
    assign ctrl   = uw;

    always_comb
    begin
        unique case (uw.jmp)
            glct_pkg::JMP_NEXT:   pc_next = pc_inc;
            glct_pkg::JMP_GOTO:   pc_next = uw.target;
            glct_pkg::JMP_WAIT:   pc_next = start ? pc_inc : pc_reg;
            glct_pkg::JMP_IFZERO: pc_next = stat.span_zero ? uw.target : pc_inc;
            glct_pkg::JMP_COLUMN: pc_next = stat.col_end ? uw.target
                                          : (stat.wrap ? pc_inc : pc_reg);
            default:              pc_next = glct_pkg::A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= glct_pkg::A_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/glct_dpath.sv
// datapath: span registers, column/row/remainder registers and item output register
`timescale 1ns / 1ps
`default_nettype none

module glct_dpath #(
    parameter int MAX_SPAN = glct_pkg::MAX_SPAN_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire glct_pkg::uword_t ctrl,
    input  wire glct_pkg::coord_t span_x,
    input  wire glct_pkg::coord_t span_y,
    output glct_pkg::stat_t       stat,
    output logic                  valid,
    output glct_pkg::coord_t      cell_x,
    output glct_pkg::coord_t      cell_y,
    output logic                  last_cell
);

    localparam int CW = $clog2(MAX_SPAN);
    localparam int RW = CW + 2;
    localparam glct_pkg::coord_t MAX_LIM = glct_pkg::coord_t'(MAX_SPAN - 1);

    glct_pkg::coord_t sx_lim;
    glct_pkg::coord_t sy_lim;

    logic [CW-1:0] sx_reg;
    logic [CW-1:0] sy_reg;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [CW-1:0] row_reg;
    logic [CW-1:0] row_next;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] rem_next;

    logic [RW-1:0] den;
    logic [RW-1:0] rem_sum;
    logic [RW-1:0] rem_step;
    logic          inc;
    logic          diag;
    logic          hit;
    logic [CW:0]   col_inc;

    logic [CW-1:0] out_x;
    logic [CW-1:0] out_y;

    logic             valid_reg;
    glct_pkg::coord_t cell_x_reg;
    glct_pkg::coord_t cell_y_reg;
    logic             last_reg;

    // clamp to the supported span and to a shallow slope
    assign sx_lim = (span_x > MAX_LIM) ? MAX_LIM : span_x;
    assign sy_lim = (span_y > sx_lim) ? sx_lim : span_y;

    assign den      = RW'({sx_reg, 1'b0});
    assign rem_sum  = rem_reg + RW'({sy_reg, 1'b0});
    assign inc      = (rem_sum >= den);
    assign rem_step = inc ? (rem_sum - den) : rem_sum;
    assign diag     = (sx_reg == sy_reg);
    assign hit      = (rem_reg == '0);
    assign col_inc  = (CW+1)'(col_reg) + (CW+1)'(1);

    assign stat.span_zero = (sx_reg == '0);
    assign stat.col_end   = (col_inc == (CW+1)'(sx_reg));
    assign stat.wrap      = inc && (rem_step != '0);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        rem_next = rem_reg;
        unique case (ctrl.op) inside
            glct_pkg::OP_NOP,
            glct_pkg::OP_LOAD:
            begin
                col_next = col_reg;
            end
            glct_pkg::OP_INIT:
            begin
                col_next = '0;
                row_next = diag ? CW'(1) : '0;
                rem_next = diag ? '0 : (RW'(sx_reg) + RW'(sy_reg));
            end
            glct_pkg::OP_STEP:
            begin
                if (!stat.col_end)
                begin
                    col_next = col_inc[CW-1:0];
                    row_next = row_reg + CW'(inc);
                    rem_next = rem_step;
                end
            end
            default:
            begin
                col_next = col_reg;
            end
        endcase
    end

    always_comb
    begin
        case (ctrl.sel)
            glct_pkg::SEL_CELL:
            begin
                out_x = col_reg;
                out_y = hit ? (row_reg - CW'(1)) : row_reg;
            end
            glct_pkg::SEL_PEND:
            begin
                out_x = col_reg;
                out_y = row_reg - CW'(1);
            end
            glct_pkg::SEL_FINAL:
            begin
                out_x = col_inc[CW-1:0];
                out_y = row_reg;
            end
            default:
            begin
                out_x = '0;
                out_y = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == glct_pkg::OP_LOAD)
        begin
            sx_reg <= CW'(sx_lim);
            sy_reg <= CW'(sy_lim);
        end
        cell_x_reg <= glct_pkg::coord_t'(out_x);
        cell_y_reg <= glct_pkg::coord_t'(out_y);
        last_reg   <= ctrl.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            rem_reg   <= rem_next;
            valid_reg <= ctrl.emit;
        end
    end

    assign valid     = valid_reg;
    assign cell_x    = cell_x_reg;
    assign cell_y    = cell_y_reg;
    assign last_cell = last_reg;

endmodule

`default_nettype wire

// File: sv/glct_checker.sv
// port-level checker for the grid line cell traversal and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "grid_line_cell_traversal_assert.svh"

module glct_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic valid,
    input wire logic last_cell
);

    `GLCT_AP_NEXT(a_accept_then_busy, clk, rst_n, start && !busy, busy)
    `GLCT_AP_NEXT(a_accept_then_quiet, clk, rst_n, start && !busy, !valid)
    `GLCT_AP_NEXT(a_last_then_quiet, clk, rst_n, valid && last_cell, !valid)
    `GLCT_AP_SAME(a_mid_item_busy, clk, rst_n, valid && !last_cell, busy)

endmodule

bind grid_line_cell_traversal glct_checker u_glct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .valid     (valid),
    .last_cell (last_cell)
);

`default_nettype wire
